// ===== rtl/tlvd_pkg.sv =====
// ----------------------------------------------------------------------------
// tlvd_pkg
// Shared types for the TLV stream deframer: parse phase, input item and
// result item layouts.
// ----------------------------------------------------------------------------
package tlvd_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 16;

  // Where the parser stands within one entry
  typedef enum logic [1:0] {
    PH_TAG,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_VALUE
  } phase_t;

  // One input item
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_buffer;
  } item_t;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0] entry_tag;
    logic [BYTE_W-1:0] value_byte;
    logic              has_byte;
    logic [LEN_W-1:0]  byte_offset;
    logic [LEN_W-1:0]  value_length;
    logic              entry_last;
    logic              buffer_done;
    logic              status;
  } result_t;

endpackage

// ===== rtl/tlvd_parser.sv =====
// ----------------------------------------------------------------------------
// tlvd_parser
// Header/value phase tracking and result formation for one byte per cycle when fire is high.
// ----------------------------------------------------------------------------
module tlvd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  tlvd_pkg::item_t  item,
  output tlvd_pkg::result_t rslt,
  output logic             rslt_hit
);
  import tlvd_pkg::*;

  phase_t             phase, phase_next;
  logic [BYTE_W-1:0]  current_tag, current_tag_next;
  logic [BYTE_W-1:0]  length_high, length_high_next;
  logic [LEN_W-1:0]   declared_length, declared_length_next;
  logic [LEN_W-1:0]   bytes_remaining, bytes_remaining_next;

  logic [LEN_W-1:0]   len_word;
  logic [LEN_W-1:0]   offset;
  logic               is_last;

  // Datapath terms
  assign len_word = {length_high, item.data_byte};
  assign offset   = declared_length - bytes_remaining;
  assign is_last  = (bytes_remaining <= LEN_W'(1));

  // Next state and result
  always_comb begin
    phase_next           = phase;
    current_tag_next     = current_tag;
    length_high_next     = length_high;
    declared_length_next = declared_length;
    bytes_remaining_next = bytes_remaining;
    rslt                 = '0;
    rslt_hit             = 1'b0;

    unique case (phase)
      PH_TAG: begin
        current_tag_next     = item.data_byte;
        declared_length_next = '0;
        phase_next           = PH_LEN_HI;
        if (item.end_of_buffer) begin
          rslt_hit         = 1'b1;
          rslt.entry_tag   = item.data_byte;
          rslt.buffer_done = 1'b1;
          rslt.status      = 1'b1;
        end
      end
      PH_LEN_HI: begin
        length_high_next = item.data_byte;
        phase_next       = PH_LEN_LO;
        if (item.end_of_buffer) begin
          rslt_hit         = 1'b1;
          rslt.entry_tag   = current_tag;
          rslt.buffer_done = 1'b1;
          rslt.status      = 1'b1;
        end
      end
      PH_LEN_LO: begin
        declared_length_next = len_word;
        bytes_remaining_next = len_word;
        if (len_word == '0) begin
          // empty entry: one result without data
          rslt_hit         = 1'b1;
          rslt.entry_tag   = current_tag;
          rslt.entry_last  = 1'b1;
          rslt.buffer_done = item.end_of_buffer;
          phase_next       = PH_TAG;
        end else begin
          phase_next = PH_VALUE;
          if (item.end_of_buffer) begin
            rslt_hit          = 1'b1;
            rslt.entry_tag    = current_tag;
            rslt.value_length = len_word;
            rslt.buffer_done  = 1'b1;
            rslt.status       = 1'b1;
          end
        end
      end
      PH_VALUE: begin
        bytes_remaining_next = bytes_remaining - LEN_W'(1);
        rslt_hit          = 1'b1;
        rslt.entry_tag    = current_tag;
        rslt.value_byte   = item.data_byte;
        rslt.has_byte     = 1'b1;
        rslt.byte_offset  = offset;
        rslt.value_length = declared_length;
        rslt.entry_last   = is_last;
        rslt.buffer_done  = item.end_of_buffer;
        rslt.status       = item.end_of_buffer && !is_last;
        if (is_last) begin
          phase_next = PH_TAG;
        end
      end
      default: begin
        phase_next = PH_TAG;
      end
    endcase

    // buffer end returns everything to the reset state
    if (item.end_of_buffer) begin
      phase_next           = PH_TAG;
      current_tag_next     = '0;
      length_high_next     = '0;
      declared_length_next = '0;
      bytes_remaining_next = '0;
    end
  end

  // State registers, advanced once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_TAG;
      current_tag     <= '0;
      length_high     <= '0;
      declared_length <= '0;
      bytes_remaining <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      current_tag     <= current_tag_next;
      length_high     <= length_high_next;
      declared_length <= declared_length_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

// ===== rtl/tlvd_out_stage.sv =====
// ----------------------------------------------------------------------------
// tlvd_out_stage
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module tlvd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              hit,
  input  tlvd_pkg::result_t rslt,
  input  logic              stall,
  output logic              can_load,
  output logic              valid,
  output tlvd_pkg::result_t held
);
  import tlvd_pkg::*;

  // Free when empty or being drained this cycle
  assign can_load = !valid || !stall;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load && hit;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (can_load && load && hit) begin
      held <= rslt;
    end
  end

endmodule

// ===== rtl/tlv_stream_deframer_core.sv =====
// ----------------------------------------------------------------------------
// tlv_stream_deframer_core
// Splits a byte stream into tag / 16-bit length / value entries and emits
// one result per value byte, per empty entry, or per truncated buffer end.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------
//  input   | item_valid / item_stall   | data_byte, end_of_buffer
//  output  | result_valid/result_stall | entry_tag, value_byte, has_byte,
//          |                           | byte_offset, value_length,
//          |                           | entry_last, buffer_done, status
//
//  One byte per cycle sustained while result_stall is low; an accepted byte
//  passes the input register, then the result register, to give its result.
//  Header bytes that give no result still take one pass through the parser.
//  rst is synchronous; it empties both registers and returns to tag phase.
//  A stall on the output backs up through the input register in the same cycle.
// ----------------------------------------------------------------------------
module tlv_stream_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  entry_tag,
  output logic [7:0]  value_byte,
  output logic        has_byte,
  output logic [15:0] byte_offset,
  output logic [15:0] value_length,
  output logic        entry_last,
  output logic        buffer_done,
  output logic        status
);
  import tlvd_pkg::*;

  logic    in_valid_r;
  item_t   in_item;
  logic    can_load;
  logic    fire;
  result_t rslt;
  logic    rslt_hit;
  result_t held;

  // Input register
  assign fire       = in_valid_r && can_load;
  assign item_stall = in_valid_r && !can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_r <= 1'b0;
    end else if (!item_stall) begin
      in_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_item.data_byte     <= data_byte;
      in_item.end_of_buffer <= end_of_buffer;
    end
  end

  // Parser
  tlvd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (in_item),
    .rslt     (rslt),
    .rslt_hit (rslt_hit)
  );

  // Result register
  tlvd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .hit      (rslt_hit),
    .rslt     (rslt),
    .stall    (result_stall),
    .can_load (can_load),
    .valid    (result_valid),
    .held     (held)
  );

  assign entry_tag    = held.entry_tag;
  assign value_byte   = held.value_byte;
  assign has_byte     = held.has_byte;
  assign byte_offset  = held.byte_offset;
  assign value_length = held.value_length;
  assign entry_last   = held.entry_last;
  assign buffer_done  = held.buffer_done;
  assign status       = held.status;

endmodule

// ===== rtl/tlvd_checker.sv =====
// ----------------------------------------------------------------------------
// tlvd_checker
// Port-level checks on the deframer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tlvd_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [7:0]  value_byte,
  input logic        has_byte,
  input logic [15:0] byte_offset,
  input logic [15:0] value_length,
  input logic        entry_last,
  input logic        buffer_done,
  input logic        status
);

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // Results without data carry zero byte and offset
  a_no_data_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !has_byte |-> value_byte == 8'd0 && byte_offset == 16'd0)
    else $error("dataless result has nonzero byte or offset");

  // Truncation is only reported at buffer end
  a_trunc_at_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && status |-> buffer_done && !entry_last)
    else $error("truncation without buffer end");

  // The final value byte of an entry sits at offset length - 1
  a_last_offset: assert property (@(posedge clk) disable iff (rst)
    result_valid && has_byte && entry_last |-> byte_offset == value_length - 16'd1)
    else $error("last byte at wrong offset");

  // A value byte always lies inside its entry
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && has_byte |-> byte_offset < value_length)
    else $error("value byte offset beyond entry length");

endmodule

bind tlv_stream_deframer_core tlvd_checker u_tlvd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .value_byte   (value_byte),
  .has_byte     (has_byte),
  .byte_offset  (byte_offset),
  .value_length (value_length),
  .entry_last   (entry_last),
  .buffer_done  (buffer_done),
  .status       (status)
);
